// ===== rtl/irt_pkg.sv =====
// shared constants and codes for the interval range table
`timescale 1ns / 1ps
`default_nettype none
package irt_pkg;
    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_KEY_WIDTH     = 32;
    localparam int DEF_VALUE_WIDTH   = 32;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ASSIGN = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;
endpackage
`default_nettype wire

// ===== rtl/irt_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module irt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/interval_range_table.sv =====
// interval range table: sorted boundary table with assign, lookup and clear
// one item at a time, next word accepted in the cycle the result is presented
// the scan reads entries one by one through the ram read port, each read then evaluated
// reset: synchronous active low; the init state writes entry zero, lowest key, default value
`timescale 1ns / 1ps
`default_nettype none
module interval_range_table
    import irt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int KEY_WIDTH     = DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH,
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1),
    localparam int SD_W   = ((2 * KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
    localparam int MD_W   = ((VALUE_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [VALUE_WIDTH-1:0] cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [SD_W-1:0]        s_tdata,   // begin_key, end_key, new_value
    input  wire logic [1:0]             s_tuser,   // opcode
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [MD_W-1:0]        m_tdata,   // found_value, entry_count
    output logic      [1:0]             m_tuser    // status
);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int NW = $clog2(TABLE_ENTRIES + 2);
    localparam int EW = KEY_WIDTH + VALUE_WIDTH;
    localparam logic [KEY_WIDTH-1:0] SIGN_FLIP = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_MRG_RD, S_MRG_EV,
        S_INS_B, S_INS_E, S_COMMIT, S_CLR, S_DONE
    } state_t;

    state_t                 state_reg;
    opcode_t                op_reg;
    logic [KEY_WIDTH-1:0]   b_reg, e_reg;
    logic [VALUE_WIDTH-1:0] v_reg, best_reg, last_v_reg, dflt_reg;
    logic [AW-1:0]          idx_reg;
    logic [NW-1:0]          n_reg;
    logic [CNT_W-1:0]       used_reg;
    logic                   bank_reg, ins_done_reg, scan_over_reg;
    status_t                status_reg;

    logic [EW-1:0]          rd0, rd1, rd_word, wr_word;
    logic [KEY_WIDTH-1:0]   rd_k, skey, push_k;
    logic [VALUE_WIDTH-1:0] rd_v, push_v;
    logic                   last_entry, push_en, push_do, wr_en, wr_bank;
    logic [AW-1:0]          wr_addr;

    assign rd_word    = bank_reg ? rd1 : rd0;
    assign rd_k       = rd_word[KEY_WIDTH-1:0];
    assign rd_v       = rd_word[EW-1:KEY_WIDTH];
    assign skey       = (op_reg == OP_LOOKUP) ? b_reg : e_reg;
    assign last_entry = ({1'b0, idx_reg} + 1'b1) == (AW + 1)'(used_reg);
    assign s_tready   = (state_reg == S_IDLE);

    always_comb begin
        push_en = 1'b0;
        push_k  = rd_k;
        push_v  = rd_v;
        case (state_reg)
            S_MRG_EV: push_en = ins_done_reg ? (rd_k > e_reg) : (rd_k < b_reg);
            S_INS_B: begin
                push_en = 1'b1;
                push_k  = b_reg;
                push_v  = v_reg;
            end
            S_INS_E: begin
                push_en = 1'b1;
                push_k  = e_reg;
                push_v  = best_reg;
            end
            default: push_en = 1'b0;
        endcase
        push_do = push_en && !(n_reg != '0 && last_v_reg == push_v);
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_bank = ~bank_reg;
        wr_addr = n_reg[AW-1:0];
        wr_word = {push_v, push_k};
        if (state_reg == S_INIT || state_reg == S_CLR) begin
            wr_en   = 1'b1;
            wr_bank = bank_reg;
            wr_addr = '0;
            wr_word = {dflt_reg, {KEY_WIDTH{1'b0}}};
        end else if (push_do && n_reg < NW'(TABLE_ENTRIES)) begin
            wr_en = 1'b1;
        end
    end

    irt_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_bank0 (
        .aclk(aclk), .we(wr_en && !wr_bank), .waddr(wr_addr), .wdata(wr_word),
        .raddr(idx_reg), .rdata(rd0)
    );

    irt_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_bank1 (
        .aclk(aclk), .we(wr_en && wr_bank), .waddr(wr_addr), .wdata(wr_word),
        .raddr(idx_reg), .rdata(rd1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_INIT;
            dflt_reg   <= '0;
            used_reg   <= CNT_W'(1);
            bank_reg   <= 1'b0;
            m_tvalid   <= 1'b0;
            idx_reg    <= '0;
            n_reg      <= '0;
            status_reg <= ST_DONE;
        end else begin
            if (cfg_we) begin
                dflt_reg <= cfg_wdata;
            end
            if (m_tvalid && m_tready && state_reg != S_DONE) begin
                m_tvalid <= 1'b0;
            end
            if (push_do) begin
                last_v_reg <= push_v;
                if (n_reg <= NW'(TABLE_ENTRIES)) begin
                    n_reg <= n_reg + 1'b1;
                end
            end
            case (state_reg)
                S_INIT: state_reg <= S_IDLE;
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg     <= opcode_t'(s_tuser);
                        b_reg      <= s_tdata[KEY_WIDTH-1:0] ^ SIGN_FLIP;
                        e_reg      <= s_tdata[2*KEY_WIDTH-1:KEY_WIDTH] ^ SIGN_FLIP;
                        v_reg      <= s_tdata[EW+KEY_WIDTH-1:2*KEY_WIDTH];
                        idx_reg    <= '0;
                        case (opcode_t'(s_tuser))
                            OP_LOOKUP: begin
                                status_reg <= ST_DONE;
                                state_reg  <= S_SCAN_RD;
                            end
                            OP_ASSIGN: begin
                                if ((s_tdata[KEY_WIDTH-1:0] ^ SIGN_FLIP) >=
                                    (s_tdata[2*KEY_WIDTH-1:KEY_WIDTH] ^ SIGN_FLIP)) begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_DONE;
                                end else begin
                                    status_reg <= ST_DONE;
                                    state_reg  <= S_SCAN_RD;
                                end
                            end
                            OP_CLEAR: begin
                                status_reg <= ST_DONE;
                                state_reg  <= S_CLR;
                            end
                            default: begin
                                status_reg <= ST_DONE;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN_RD: state_reg <= S_SCAN_EV;
                S_SCAN_EV: begin
                    if (rd_k <= skey) begin
                        best_reg <= rd_v;
                    end
                    if (!last_entry) begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end else if (op_reg == OP_LOOKUP) begin
                        state_reg <= S_DONE;
                    end else begin
                        idx_reg       <= '0;
                        n_reg         <= '0;
                        ins_done_reg  <= 1'b0;
                        scan_over_reg <= 1'b0;
                        state_reg     <= S_MRG_RD;
                    end
                end
                S_MRG_RD: state_reg <= S_MRG_EV;
                S_MRG_EV: begin
                    if (!ins_done_reg && rd_k >= b_reg) begin
                        state_reg <= S_INS_B;
                    end else if (!last_entry) begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_MRG_RD;
                    end else if (ins_done_reg) begin
                        state_reg <= S_COMMIT;
                    end else begin
                        scan_over_reg <= 1'b1;
                        state_reg     <= S_INS_B;
                    end
                end
                S_INS_B: state_reg <= S_INS_E;
                S_INS_E: begin
                    ins_done_reg <= 1'b1;
                    state_reg    <= scan_over_reg ? S_COMMIT : S_MRG_EV;
                end
                S_COMMIT: begin
                    if (n_reg > NW'(TABLE_ENTRIES)) begin
                        status_reg <= ST_FULL;
                    end else begin
                        bank_reg <= ~bank_reg;
                        used_reg <= n_reg[CNT_W-1:0];
                    end
                    state_reg <= S_DONE;
                end
                S_CLR: begin
                    used_reg  <= CNT_W'(1);
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid || m_tready) begin
                        m_tvalid  <= 1'b1;
                        m_tuser   <= status_reg;
                        m_tdata   <= MD_W'({used_reg, (op_reg == OP_LOOKUP) ?
                                            best_reg : {VALUE_WIDTH{1'b0}}});
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg != '0 && used_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("boundary count out of range");
    a_bank_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(bank_reg) |-> $past(state_reg == S_COMMIT))
        else $error("bank swapped outside commit");
    a_fill_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= NW'(TABLE_ENTRIES + 1))
        else $error("merge count overran");
`endif
endmodule
`default_nettype wire

// ===== test/interval_range_table_tb.sv =====
// testbench for the interval range table: directed and random stream items
// against a behavioral table model
`timescale 1ns / 1ps
module interval_range_table_tb;
    import irt_pkg::*;

    localparam int ENTRIES     = DEF_TABLE_ENTRIES;
    localparam int LIMIT       = 2000000;
    localparam int DRAIN_WAIT  = 300;
    localparam int HOLD_CYCLES = 600;

    typedef logic signed [31:0] word_t;

    typedef struct {
        word_t      found;
        status_t    status;
        logic [6:0] count;
    } table_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // begin_key, end_key, new_value
    logic [1:0]  s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // found_value, entry_count
    logic [1:0]  m_tuser;   // status

    interval_range_table u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    // behavioral copy of the table
    word_t       tbl_keys [ENTRIES];
    word_t       tbl_vals [ENTRIES];
    int          tbl_used;
    word_t       dflt_value;
    word_t       merge_keys [ENTRIES + 2];
    word_t       merge_vals [ENTRIES + 2];
    int          merge_n;

    table_result_t pending_results [$];
    int          errors;
    int          cycles;
    int          items_sent;
    int          results_seen;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_req;
    int          hold_seen;
    logic        rx_hold;
    int          n_full;
    int          n_empty;

    function automatic word_t table_value_at(word_t k);
        int best;
        best = 0;
        for (int i = 0; i < tbl_used; i++)
            if (tbl_keys[i] <= k) best = i;
        return tbl_vals[best];
    endfunction

    function automatic void merge_push(word_t k, word_t v);
        if (merge_n > 0 && merge_vals[merge_n-1] == v) return;
        if (merge_n < ENTRIES + 2) begin
            merge_keys[merge_n] = k;
            merge_vals[merge_n] = v;
            merge_n++;
        end
    endfunction

    function automatic void table_reset();
        tbl_keys[0] = 32'sh8000_0000;
        tbl_vals[0] = dflt_value;
        tbl_used = 1;
    endfunction

    function automatic table_result_t table_apply(opcode_t op, word_t b, word_t e, word_t v);
        table_result_t r;
        word_t endv;
        r.found = '0;
        r.status = ST_DONE;
        case (op)
            OP_LOOKUP: r.found = table_value_at(b);
            OP_ASSIGN: begin
                if (b >= e) begin
                    r.status = ST_EMPTY;
                end else begin
                    endv = table_value_at(e);
                    merge_n = 0;
                    for (int i = 0; i < tbl_used; i++)
                        if (tbl_keys[i] < b) merge_push(tbl_keys[i], tbl_vals[i]);
                    merge_push(b, v);
                    merge_push(e, endv);
                    for (int i = 0; i < tbl_used; i++)
                        if (tbl_keys[i] > e) merge_push(tbl_keys[i], tbl_vals[i]);
                    if (merge_n > ENTRIES) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int i = 0; i < merge_n; i++) begin
                            tbl_keys[i] = merge_keys[i];
                            tbl_vals[i] = merge_vals[i];
                        end
                        tbl_used = merge_n;
                    end
                end
            end
            OP_CLEAR: table_reset();
            default: ;
        endcase
        r.count = 7'(tbl_used);
        return r;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // long receiver hold-off
    initial begin
        rx_hold <= 1'b0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        end
    end

    // result checker and receiver stalls
    always @(posedge aclk) begin
        table_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word found=%0d status=%0d count=%0d", $time,
                         $signed(m_tdata[31:0]), m_tuser, m_tdata[38:32]);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata[31:0] !== exp_r.found) begin
                    $display("%0t: found_value expected %0d actual %0d", $time,
                             exp_r.found, $signed(m_tdata[31:0]));
                    errors++;
                end
                if (m_tuser !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, m_tuser);
                    errors++;
                end
                if (m_tdata[38:32] !== exp_r.count) begin
                    $display("%0t: entry_count expected %0d actual %0d", $time,
                             exp_r.count, m_tdata[38:32]);
                    errors++;
                end
            end
        end
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_item(opcode_t op, word_t b, word_t e, word_t v);
        table_result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {v, e, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = table_apply(op, b, e, v);
        if (r.status == ST_FULL) n_full++;
        if (r.status == ST_EMPTY) n_empty++;
        pending_results.push_back(r);
        items_sent++;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_default(word_t v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        dflt_value = v;
    endtask

    function automatic word_t rand_key();
        if ($urandom_range(99) < 75) return $urandom_range(200) - 100;
        return $urandom;
    endfunction

    function automatic word_t rand_value();
        if ($urandom_range(99) < 75) return $urandom_range(3);
        return $urandom;
    endfunction

    task automatic test_directed();
        send_item(OP_LOOKUP, 32'sh8000_0000, 0, 0);
        send_item(OP_LOOKUP, 32'sh7fff_ffff, 32'shffff_ffff, 32'shffff_ffff);
        send_item(OP_ASSIGN, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_item(OP_LOOKUP, 32'sh7fff_fffe, 0, 0);
        send_item(OP_LOOKUP, 32'sh7fff_ffff, 0, 0);
        send_item(OP_ASSIGN, 10, 10, 5);
        send_item(OP_ASSIGN, 20, -20, 5);
        send_item(OP_ASSIGN, -5, 5, 32'sh8000_0000);
        send_item(OP_ASSIGN, 0, 3, 32'sh8000_0000);
        send_item(OP_ASSIGN, -5, 5, 32'sh7fff_ffff);
        send_item(OP_LOOKUP, -5, 0, 0);
        send_item(OP_LOOKUP, 4, 0, 0);
        send_item(OP_LOOKUP, 5, 0, 0);
        send_item(OP_NONE, 32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff);
        send_item(OP_CLEAR, 0, 0, 0);
        send_item(OP_LOOKUP, 0, 0, 0);
    endtask

    task automatic test_overflow();
        send_item(OP_CLEAR, 0, 0, 0);
        for (int i = 0; i < 34; i++)
            send_item(OP_ASSIGN, i * 16, i * 16 + 8, 1);
        send_item(OP_LOOKUP, 8 * 16 + 4, 0, 0);
        send_item(OP_ASSIGN, 0, 33 * 16 + 8, 1);
    endtask

    task automatic test_config();
        word_t vals [4];
        vals = '{32'sh8000_0000, 32'sh7fff_ffff, 32'shffff_ffff, 32'sh5a5a_a5a5};
        foreach (vals[i]) begin
            write_default(vals[i]);
            send_item(OP_LOOKUP, 3, 0, 0);
            send_item(OP_CLEAR, 0, 0, 0);
            send_item(OP_LOOKUP, 3, 0, 0);
            send_item(OP_ASSIGN, 0, 100, vals[i]);
        end
        write_default(0);
        send_item(OP_CLEAR, 0, 0, 0);
    endtask

    task automatic test_random(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 48)
                send_item(OP_ASSIGN, rand_key(), rand_key(), rand_value());
            else if (pick < 93)
                send_item(OP_LOOKUP, rand_key(), $urandom, $urandom);
            else if (pick < 96)
                send_item(OP_CLEAR, $urandom, $urandom, $urandom);
            else
                send_item(OP_NONE, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_backpressure();
        drain();
        hold_req++;
        for (int i = 0; i < 6; i++)
            send_item(OP_ASSIGN, rand_key(), rand_key(), rand_value());
        drain();
        send_item(OP_LOOKUP, rand_key(), 0, 0);
    endtask

    initial begin
        errors = 0; cycles = 0; items_sent = 0; results_seen = 0;
        n_full = 0; n_empty = 0; hold_req = 0;
        tx_idle_pct = 31; rx_idle_pct = 86;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_LOOKUP;
        dflt_value = 0;
        table_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_overflow();
        test_config();
        test_random(480);
        test_backpressure();
        drain();
        tx_idle_pct = 86; rx_idle_pct = 31;
        test_random(480);
        drain();
        tx_idle_pct = 0; rx_idle_pct = 0;
        test_random(420);

        drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("run covered %0d items and %0d results, %0d rejected as full, %0d empty",
                 items_sent, results_seen, n_full, n_empty);
        $display("default value writes at both extremes, stalls and long back-pressure");
        if (errors == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/irt_pkg.sv
rtl/irt_ram.sv
rtl/interval_range_table.sv
test/interval_range_table_tb.sv
